/* rtl/core/rwdcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk finder package
// Field widths, tag constants, status codes and the parser phase type.
// ----------------------------------------------------------------------------
package rwdcf_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 32;

  // Little-endian four-character codes as they appear after assembly.
  localparam logic [LEN_W-1:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [LEN_W-1:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [LEN_W-1:0] TAG_DATA = 32'h6174_6164;

  // Result status codes.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_FOUND    = 3'd0;
  localparam status_t ST_NOT_RIFF = 3'd1;
  localparam status_t ST_NOT_WAVE = 3'd2;
  localparam status_t ST_NO_DATA  = 3'd3;
  localparam status_t ST_TRUNC    = 3'd4;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_RIFF_TAG  = 7'b000_0001,
    PH_RIFF_LEN  = 7'b000_0010,
    PH_WAVE_TAG  = 7'b000_0100,
    PH_CHUNK_ID  = 7'b000_1000,
    PH_CHUNK_LEN = 7'b001_0000,
    PH_SKIP      = 7'b010_0000,
    PH_DONE      = 7'b100_0000
  } phase_t;

endpackage : rwdcf_pkg
`default_nettype wire

/* rtl/core/rwdcf_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte stream channel
// Valid/ready channel carrying one file byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface rwdcf_in_if
  import rwdcf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              final_byte;

  modport source (output valid, output stream_byte, output final_byte, input ready);
  modport sink   (input valid, input stream_byte, input final_byte, output ready);
endinterface : rwdcf_in_if
`default_nettype wire

/* rtl/core/rwdcf_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parse result channel
// Valid/ready channel carrying the parse status and the data chunk length.
// ----------------------------------------------------------------------------
interface rwdcf_out_if
  import rwdcf_pkg::*;
;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [LEN_W-1:0] data_length;

  modport source (output valid, output status, output data_length, input ready);
  modport sink   (input valid, input status, input data_length, output ready);
endinterface : rwdcf_out_if
`default_nettype wire

/* rtl/core/riff_wave_data_chunk_finder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE data chunk finder
// Walks a WAV file byte by byte and reports the data chunk length or an error.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one byte of the file per transaction, with final_byte set
//   on the last byte. out_ch carries at most one result per file: status
//   (found, not RIFF, not WAVE, no data chunk, truncated) and data_length.
//   A byte is captured in an input register and parsed from there; a
//   result it causes is then held in the result register. One byte per
//   cycle is sustained while no result is stuck on out_ch; the rate is set
//   by the single parse step between the input register and the result
//   register.
//   While a result waits on out_ch, a captured byte holds and in_ch
//   accepts nothing new behind it until the result is taken; otherwise in_ch stays
//   ready while the result register is full but draining.
//   After a result, bytes are dropped until the final byte, which rearms
//   the parser for the next file. A final byte that arrives before any
//   result and causes no other result produces the truncated status.
//   Reset (rst_n low, synchronous) empties both registers and arms the
//   parser to expect the RIFF tag.
// ----------------------------------------------------------------------------
module riff_wave_data_chunk_finder
  import rwdcf_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  rwdcf_in_if.sink      in_ch,
  rwdcf_out_if.source   out_ch
);

  // Input register.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_fin_r;

  // Parser state.
  phase_t           phase_r, phase_nxt;
  logic [1:0]       byte_idx_r, byte_idx_nxt;
  logic [LEN_W-1:0] word_r, word_nxt;
  logic             is_data_r, is_data_nxt;
  logic [LEN_W-1:0] skip_r, skip_nxt;
  logic             pad_r, pad_nxt;
  logic [LEN_W-1:0] consumed_r, consumed_nxt;
  logic [LEN_W-1:0] limit_r, limit_nxt;

  // Result register.
  logic             out_valid_r;
  status_t          out_status_r;
  logic [LEN_W-1:0] out_len_r;

  logic             advance;
  logic             emit;
  status_t          st;
  logic [LEN_W-1:0] dlen;
  logic [LEN_W-1:0] w;
  logic [LEN_W+1:0] total;

  // The captured byte moves on unless a result is stuck at the output.
  assign advance     = !(out_valid_r && !out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  // Input capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.stream_byte;
      s1_fin_r  <= in_ch.final_byte;
    end
  end

  // The assembled word with the current byte shifted in at the top.
  assign w     = {s1_byte_r, word_r[LEN_W-1:BYTE_W]};
  assign total = {2'b00, consumed_r} + {2'b00, w} + (LEN_W+2)'(8) + {{(LEN_W+1){1'b0}}, w[0]};

  // One parse step per byte.
  always_comb begin
    phase_nxt    = phase_r;
    byte_idx_nxt = byte_idx_r;
    word_nxt     = word_r;
    is_data_nxt  = is_data_r;
    skip_nxt     = skip_r;
    pad_nxt      = pad_r;
    consumed_nxt = consumed_r;
    limit_nxt    = limit_r;
    emit         = 1'b0;
    st           = ST_FOUND;
    dlen         = '0;

    if (phase_r == PH_DONE) begin
      if (s1_fin_r) begin
        phase_nxt    = PH_RIFF_TAG;
        byte_idx_nxt = 2'd0;
      end
    end else begin
      if (phase_r == PH_SKIP) begin
        // Body bytes count down, then an optional pad byte.
        if (skip_r != '0) begin
          skip_nxt = skip_r - LEN_W'(1);
          if (skip_r == LEN_W'(1) && !pad_r) begin
            phase_nxt = PH_CHUNK_ID;
          end
        end else begin
          pad_nxt   = 1'b0;
          phase_nxt = PH_CHUNK_ID;
        end
      end else begin
        word_nxt = w;
        if (byte_idx_r != 2'd3) begin
          byte_idx_nxt = byte_idx_r + 2'd1;
        end else begin
          byte_idx_nxt = 2'd0;
          case (phase_r)
            PH_RIFF_LEN: begin
              limit_nxt = w - LEN_W'(4);
              phase_nxt = PH_WAVE_TAG;
            end
            PH_WAVE_TAG: begin
              if (w != TAG_WAVE) begin
                emit = 1'b1;
                st   = ST_NOT_WAVE;
              end else begin
                consumed_nxt = '0;
                if (limit_r == '0) begin
                  emit = 1'b1;
                  st   = ST_NO_DATA;
                end else begin
                  phase_nxt = PH_CHUNK_ID;
                end
              end
            end
            PH_CHUNK_ID: begin
              is_data_nxt = (w == TAG_DATA);
              phase_nxt   = PH_CHUNK_LEN;
            end
            PH_CHUNK_LEN: begin
              if (is_data_r) begin
                emit = 1'b1;
                st   = ST_FOUND;
                dlen = w;
              end else if (total >= {2'b00, limit_r}) begin
                emit = 1'b1;
                st   = ST_NO_DATA;
              end else begin
                consumed_nxt = total[LEN_W-1:0];
                skip_nxt     = w;
                pad_nxt      = w[0];
                phase_nxt    = (w == '0) ? PH_CHUNK_ID : PH_SKIP;
              end
            end
            default: begin
              if (w != TAG_RIFF) begin
                emit = 1'b1;
                st   = ST_NOT_RIFF;
              end else begin
                phase_nxt = PH_RIFF_LEN;
              end
            end
          endcase
        end
      end

      // A last byte with nothing else to report means the file was cut short.
      if (!emit && s1_fin_r) begin
        emit = 1'b1;
        st   = ST_TRUNC;
        dlen = '0;
      end

      // After a result, rearm on the last byte or wait for it.
      if (emit) begin
        byte_idx_nxt = 2'd0;
        phase_nxt    = s1_fin_r ? PH_RIFF_TAG : PH_DONE;
      end
    end
  end

  // Parser state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RIFF_TAG;
      byte_idx_r <= 2'd0;
    end else if (s1_valid_r && advance) begin
      phase_r    <= phase_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
    if (s1_valid_r && advance) begin
      word_r     <= word_nxt;
      is_data_r  <= is_data_nxt;
      skip_r     <= skip_nxt;
      pad_r      <= pad_nxt;
      consumed_r <= consumed_nxt;
      limit_r    <= limit_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && emit;
    end
    if (advance && s1_valid_r && emit) begin
      out_status_r <= st;
      out_len_r    <= dlen;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data_length = out_len_r;

endmodule : riff_wave_data_chunk_finder
`default_nettype wire
